### rtl/core/side_by_side_anaglyph_converter_assert.svh
// Assertion macros used by the converter's checker.
`ifndef SIDE_BY_SIDE_ANAGLYPH_CONVERTER_ASSERT_SVH
`define SIDE_BY_SIDE_ANAGLYPH_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled while dis is high.
`define SBS_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while dis is high.
`define SBS_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/sbs_pkg.sv
// Shared types and constants for the side-by-side anaglyph converter.
`timescale 1ns / 1ps

package sbs_pkg;

    localparam int MAX_HALF_WIDTH = 2048;
    localparam int ADDR_W         = $clog2(MAX_HALF_WIDTH);
    localparam int HW_W           = 12;
    localparam int MODE_W         = 3;

    // register indexes of the configuration port
    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_HALF = 1'b1;

    // mixing modes; codes 5 to 7 fall back to true
    typedef enum logic [MODE_W-1:0] {
        MODE_TRUE      = 3'd0,
        MODE_GRAY      = 3'd1,
        MODE_COLOR     = 3'd2,
        MODE_HALFCOLOR = 3'd3,
        MODE_OPTIMIZED = 3'd4
    } t_mode;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // weights in unsigned 0.16
    localparam logic [15:0] W_LUMA_R = 16'd19595;
    localparam logic [15:0] W_LUMA_G = 16'd38470;
    localparam logic [15:0] W_LUMA_B = 16'd7471;
    localparam logic [15:0] W_OPT_G  = 16'd45875;
    localparam logic [15:0] W_OPT_B  = 16'd19661;

endpackage

### rtl/core/sbs_mix.sv
// Anaglyph mixing of one left/right pixel pair.
`timescale 1ns / 1ps

module sbs_mix
    import sbs_pkg::*;
(
    input  t_rgb              i_left,
    input  t_rgb              i_right,
    input  logic [MODE_W-1:0] i_mode,
    output t_rgb              o_mix
);

    logic [23:0] luma_l_sum;
    logic [23:0] luma_r_sum;
    logic [23:0] opt_sum;
    logic [7:0]  luma_l;
    logic [7:0]  luma_r;

    // weights sum to 1.0, so no sum overflows 24 bits
    assign luma_l_sum = 24'(i_left.red) * 24'(W_LUMA_R)
                      + 24'(i_left.green) * 24'(W_LUMA_G)
                      + 24'(i_left.blue) * 24'(W_LUMA_B);
    assign luma_r_sum = 24'(i_right.red) * 24'(W_LUMA_R)
                      + 24'(i_right.green) * 24'(W_LUMA_G)
                      + 24'(i_right.blue) * 24'(W_LUMA_B);
    assign opt_sum    = 24'(i_left.green) * 24'(W_OPT_G)
                      + 24'(i_left.blue) * 24'(W_OPT_B);

    assign luma_l = luma_l_sum[23:16];
    assign luma_r = luma_r_sum[23:16];

    always_comb begin
        case (i_mode)
            MODE_GRAY: begin
                o_mix = '{red: luma_l, green: luma_r, blue: luma_r};
            end
            MODE_COLOR: begin
                o_mix = '{red: i_left.red, green: i_right.green, blue: i_right.blue};
            end
            MODE_HALFCOLOR: begin
                o_mix = '{red: luma_l, green: i_right.green, blue: i_right.blue};
            end
            MODE_OPTIMIZED: begin
                o_mix = '{red: opt_sum[23:16], green: i_right.green, blue: i_right.blue};
            end
            default: begin
                o_mix = '{red: luma_l, green: 8'd0, blue: luma_r};
            end
        endcase
    end

endmodule

### rtl/core/side_by_side_anaglyph_converter.sv
// Top level of the side-by-side stereo to anaglyph converter.
`timescale 1ns / 1ps

// Takes one RGB pixel per clock while o_stall is low, of a side-by-side
// stereo stream in raster order: each row is half_width left-eye pixels
// followed by half_width right-eye pixels. Left pixels go into a half-line
// store and give no beat out; each right pixel is paired with the left pixel
// at the same offset and gives one anaglyph beat, row_last high on the last
// of the row. Throughput is one pixel per clock while not stalled, bounded
// by the single port of the half-line store (one write or one read per
// cycle). An input beat is registered in stage 1 with the store read, then
// mixed into the output register. The input stalls only when both internal
// stages hold data and the output is stalled. The store has no reset and
// needs no clearing pass; row_start, or running past the end of a row, sets
// the column back to zero. Configure (mode, half_width) only while no beats
// are in flight; half_width 0 acts as 1, values above 2048 as 2048.

module side_by_side_anaglyph_converter
    import sbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [HW_W-1:0]   i_cfg_data,
    // input pixels
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_pixel_red,
    input  logic [7:0]        i_pixel_green,
    input  logic [7:0]        i_pixel_blue,
    input  logic              i_row_start,
    // anaglyph pixels
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_out_red,
    output logic [7:0]        o_out_green,
    output logic [7:0]        o_out_blue,
    output logic              o_row_last
);

    // configuration, half width kept already clamped
    logic [MODE_W-1:0] r_mode;
    logic [HW_W-1:0]   r_hw;
    logic [HW_W:0]     r_hw2;
    logic [HW_W-1:0]   n_hw;

    // column tracking
    logic [HW_W-1:0]   r_col;
    logic [HW_W-1:0]   col;
    logic [HW_W:0]     col_inc;
    logic [HW_W-1:0]   off;
    logic              is_right;

    // half-line store
    logic [23:0]       r_store [MAX_HALF_WIDTH];
    t_rgb              r_rd_data;

    // stage 1: store read in flight
    logic              r_s1_valid;
    t_rgb              r_s1_right;
    logic              r_s1_last;

    // stage 2: output register
    logic              r_out_valid;
    t_rgb              r_out;
    logic              r_out_last;

    logic              in_beat;
    logic              s1_load;
    logic              out_take;
    t_rgb              pix_in;
    t_rgb              mix;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_hw = HW_W'(1);
        end else if (i_cfg_data > HW_W'(MAX_HALF_WIDTH)) begin
            n_hw = HW_W'(MAX_HALF_WIDTH);
        end else begin
            n_hw = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TRUE;
            r_hw   <= HW_W'(640);
            r_hw2  <= (HW_W + 1)'(1280);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE: begin
                    r_mode <= i_cfg_data[MODE_W-1:0];
                end
                CFG_HALF: begin
                    r_hw  <= n_hw;
                    r_hw2 <= {n_hw, 1'b0};
                end
                default: begin
                end
            endcase
        end
    end

    // handshake: stage 1 moves on when the output register can take it
    assign out_take = !r_out_valid || !i_stall;
    assign s1_load  = !r_s1_valid || out_take;
    assign o_stall  = !s1_load;
    assign in_beat  = i_valid && s1_load;

    // column of this beat; a stale column past the row starts a new row
    always_comb begin
        if (i_row_start || {1'b0, r_col} >= r_hw2) begin
            col = '0;
        end else begin
            col = r_col;
        end
        col_inc  = {1'b0, col} + 1'b1;
        is_right = col >= r_hw;
        off      = col - r_hw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (in_beat) begin
            r_col <= (col_inc >= r_hw2) ? '0 : col_inc[HW_W-1:0];
        end
    end

    assign pix_in = '{red: i_pixel_red, green: i_pixel_green, blue: i_pixel_blue};

    always_ff @(posedge i_clk) begin
        if (in_beat && !is_right) begin
            r_store[col[ADDR_W-1:0]] <= pix_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat && is_right) begin
            r_rd_data <= r_store[off[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= in_beat && is_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat && is_right) begin
            r_s1_right <= pix_in;
            r_s1_last  <= off == (r_hw - 1'b1);
        end
    end

    sbs_mix u_mix (
        .i_left  (r_rd_data),
        .i_right (r_s1_right),
        .i_mode  (r_mode),
        .o_mix   (mix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take && r_s1_valid) begin
            r_out      <= mix;
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_red   = r_out.red;
    assign o_out_green = r_out.green;
    assign o_out_blue  = r_out.blue;
    assign o_row_last  = r_out_last;

endmodule

### rtl/core/sbs_chk.sv
// Port-level checker for the anaglyph converter, bound to the top level.
`timescale 1ns / 1ps
`include "side_by_side_anaglyph_converter_assert.svh"

module sbs_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_stall,
    input logic       o_stall,
    input logic       o_valid,
    input logic [7:0] o_out_red,
    input logic [7:0] o_out_green,
    input logic [7:0] o_out_blue,
    input logic       o_row_last
);

    // nothing comes out of reset
    `SBS_ASSERT_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !o_valid, "beat out after reset")

    // input only stalls behind a stalled, full output
    `SBS_ASSERT_NOW(a_stall_cause, i_clk, !i_rst_n, o_stall, o_valid && i_stall, "needless input stall")

    // a stalled beat stays
    `SBS_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_valid && i_stall, o_valid, "stalled beat dropped")

    `SBS_ASSERT_NEXT(a_out_stable, i_clk, !i_rst_n, o_valid && i_stall, $stable({o_out_red, o_out_green, o_out_blue, o_row_last}), "stalled beat changed")

endmodule

bind side_by_side_anaglyph_converter sbs_chk u_sbs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_stall     (i_stall),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .o_out_red   (o_out_red),
    .o_out_green (o_out_green),
    .o_out_blue  (o_out_blue),
    .o_row_last  (o_row_last)
);
